// ===== hw/rtl/tilt_pkg.sv =====
// ----------------------------------------------------------------------------
// tilt_pkg
// shared types, widths and the cordic angle table for the tilt angle filter
// ----------------------------------------------------------------------------
`default_nettype none

package tilt_pkg;

  localparam int WINDOW       = 10;
  localparam int CORDIC_STEPS = 16;

  localparam int DEG180_Q8 = 46080;
  localparam int DEG90_Q8  = 23040;
  localparam int DEG90_Q16 = 5898240;

  // square root datapath
  localparam int SQ_W   = 33;
  localparam int RIN_W  = 50;
  localparam int ROOT_W = 25;
  localparam int REM_W  = 27;
  localparam int ROOT_N = 25;
  localparam int CNT_W  = 5;

  // cordic datapath
  localparam int CV_W   = 27;
  localparam int CZ_W   = 25;
  localparam int ATAN_W = 22;

  // moving average
  localparam int SUMX_W = $clog2(WINDOW * DEG180_Q8 + WINDOW / 2 + 1);
  localparam int SUMY_W = $clog2(WINDOW * DEG90_Q8 + WINDOW / 2 + 1);

  // divide by the window as a multiply by its rounded-up reciprocal,
  // exact for every numerator below 2**SUMX_W
  localparam int DIV_SH    = SUMX_W + $clog2(WINDOW);
  localparam int DIV_MUL   = (2 ** DIV_SH + WINDOW - 1) / WINDOW;
  localparam int DIV_MUL_W = DIV_SH - $clog2(WINDOW) + 1;

  typedef struct packed {
    logic signed [15:0] acc_first;
    logic signed [15:0] acc_second;
    logic signed [15:0] acc_third;
  } tilt_in_t;

  typedef struct packed {
    logic [15:0] tilt_x;
    logic [14:0] tilt_y;
    logic [15:0] avg_tilt_x;
    logic [14:0] avg_tilt_y;
    logic        undefined_y;
  } tilt_out_t;

  typedef struct packed {
    logic [15:0] tx;
    logic [14:0] ty;
    logic        undef;
  } tilt_res_t;

  typedef struct packed {
    logic [15:0] x;
    logic [14:0] y;
  } tilt_hist_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [ATAN_W-1:0] atan_tbl(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/accel_tilt_angle_filter.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_angle_filter: tilt angles from one accelerometer sample, boxcar-smoothed
// path from request to result: 25-step square root, two 16-step cordic passes
// on one rotator, reciprocal multiply for the window average; the first pass is
// skipped when y or z is zero, the second when x or the magnitude is zero
// one request at a time, next one taken the cycle after the result registers
// synchronous active-low reset clears the window and sums
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_angle_filter
  import tilt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire tilt_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output tilt_out_t      out_data
);

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_CALC = 5'b00010,
    T_SUM  = 5'b00100,
    T_DIV  = 5'b01000,
    T_OUT  = 5'b10000
  } top_st_t;

  top_st_t             st_r;
  logic                in_acc, core_done, load_out;
  tilt_res_t           core_res;
  tilt_res_t           res_r;
  tilt_hist_t          chain [WINDOW+1];
  logic [SUMX_W-1:0]   sum_x_r;
  logic [SUMY_W-1:0]   sum_y_r;
  logic [SUMX_W-1:0]   num_x_r, num_y_r;
  logic [SUMX_W+DIV_MUL_W-1:0] prod_x, prod_y;
  tilt_out_t           out_r;
  logic                out_valid_r;

  assign in_stall = (st_r != T_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_out = (st_r == T_OUT) && (!out_valid_r || !out_stall);

  tilt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .opnd  (in_data),
    .done  (core_done),
    .res   (core_res)
  );

  // history chain, oldest entry falls out of the last cell
  assign chain[0].x = core_res.tx;
  assign chain[0].y = core_res.ty;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    tilt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (core_done),
      .d        (chain[g]),
      .q        (chain[g+1])
    );
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
    end else begin
      case (st_r)
        T_IDLE: if (in_acc) st_r <= T_CALC;
        T_CALC: if (core_done) st_r <= T_SUM;
        T_SUM:  st_r <= T_DIV;
        T_DIV:  st_r <= T_OUT;
        T_OUT:  if (load_out) st_r <= T_IDLE;
        default: st_r <= T_IDLE;
      endcase
    end
  end

  // running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else if (core_done) begin
      sum_x_r <= sum_x_r - SUMX_W'(chain[WINDOW].x) + SUMX_W'(core_res.tx);
      sum_y_r <= sum_y_r - SUMY_W'(chain[WINDOW].y) + SUMY_W'(core_res.ty);
    end
  end

  // reciprocal products for both averages
  always_comb begin
    prod_x = num_x_r * DIV_MUL_W'(DIV_MUL);
    prod_y = num_y_r * DIV_MUL_W'(DIV_MUL);
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      res_r <= core_res;
    end
    if (st_r == T_SUM) begin
      num_x_r <= sum_x_r + SUMX_W'(WINDOW / 2);
      num_y_r <= SUMX_W'(sum_y_r) + SUMX_W'(WINDOW / 2);
    end else if (st_r == T_DIV) begin
      num_x_r <= SUMX_W'(prod_x >> DIV_SH);
      num_y_r <= SUMX_W'(prod_y >> DIV_SH);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.tilt_x      <= res_r.tx;
      out_r.tilt_y      <= res_r.ty;
      out_r.avg_tilt_x  <= num_x_r[15:0];
      out_r.avg_tilt_y  <= num_y_r[14:0];
      out_r.undefined_y <= res_r.undef;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> st_r == T_CALC)
    else $error("core finished outside of calc phase");

  a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == T_OUT && out_valid_r && out_stall) |=> st_r == T_OUT)
    else $error("result overwritten while output stalled");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.undefined_y) |-> out_r.tilt_y == '0)
    else $error("undefined tilt_y not zero");

  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.avg_tilt_x <= 16'(DEG180_Q8)
                     && out_r.avg_tilt_y <= 15'(DEG90_Q8)))
    else $error("average out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tilt_cell.sv =====
// ----------------------------------------------------------------------------
// tilt_cell
// one history slot of the boxcar window, passes its angles on each shift
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_cell
  import tilt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       shift_en,
  input  wire tilt_hist_t d,
  output tilt_hist_t      q
);

  tilt_hist_t q_r;

  // history starts cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tilt_core.sv =====
// ----------------------------------------------------------------------------
// tilt_core
// sequential angle engine: squares, bit-pair square root, shared cordic rotator
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_core
  import tilt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire tilt_in_t opnd,
  output logic          done,
  output tilt_res_t     res
);

  typedef enum logic [9:0] {
    C_IDLE = 10'b0000000001,
    C_MUL  = 10'b0000000010,
    C_SUM  = 10'b0000000100,
    C_ROOT = 10'b0000001000,
    C_LD1  = 10'b0000010000,
    C_ANG1 = 10'b0000100000,
    C_FIN1 = 10'b0001000000,
    C_LD2  = 10'b0010000000,
    C_ANG2 = 10'b0100000000,
    C_DONE = 10'b1000000000
  } core_st_t;

  core_st_t                st_r;
  logic [15:0]             mx_r, my_r, mz_r;
  logic                    zneg_r, undef_r;
  logic [31:0]             sqy_r, sqz_r;
  logic [RIN_W-1:0]        rin_r;
  logic [REM_W-1:0]        rem_r;
  logic [ROOT_W-1:0]       root_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [CV_W-1:0]  cx_r, cy_r;
  logic signed [CZ_W-1:0]  cz_r;
  logic [14:0]             a1_r, a2_r;

  logic [REM_W-1:0]        rem_sh, trial;
  logic signed [CV_W-1:0]  xs, ys, cx_nxt, cy_nxt;
  logic signed [CZ_W-1:0]  cz_nxt, atn;
  logic signed [15:0]      ax, ay, az;

  // clamp to 0..90 degrees and round half up to 8 fraction bits
  function automatic logic [14:0] rnd_q8(input logic signed [CZ_W-1:0] z);
    logic [23:0] t;
    if (z < 0) begin
      return 15'd0;
    end else if (z > CZ_W'(DEG90_Q16)) begin
      return 15'(DEG90_Q8);
    end
    t = 24'(z) + 24'd128;
    return t[22:8];
  endfunction

  assign ax = opnd.acc_first;
  assign az = opnd.acc_second;
  assign ay = opnd.acc_third;

  // one restoring square root step on the next bit pair
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], rin_r[RIN_W-1 -: 2]};
    trial  = {root_r, 2'b01};
  end

  // one cordic vectoring step
  always_comb begin
    xs  = cx_r >>> cnt_r;
    ys  = cy_r >>> cnt_r;
    atn = CZ_W'($signed({1'b0, atan_tbl(cnt_r)}));
    if (!cy_r[CV_W-1]) begin
      cx_nxt = cx_r + ys;
      cy_nxt = cy_r - xs;
      cz_nxt = cz_r + atn;
    end else begin
      cx_nxt = cx_r - ys;
      cy_nxt = cy_r + xs;
      cz_nxt = cz_r - atn;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      case (st_r)
        C_IDLE: if (start) st_r <= C_MUL;
        C_MUL:  st_r <= C_SUM;
        C_SUM:  st_r <= C_ROOT;
        C_ROOT: if (cnt_r == CNT_W'(ROOT_N - 1)) st_r <= C_LD1;
        C_LD1: begin
          if (my_r == '0 || mz_r == '0) st_r <= C_LD2;
          else st_r <= C_ANG1;
        end
        C_ANG1: if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) st_r <= C_FIN1;
        C_FIN1: st_r <= C_LD2;
        C_LD2: begin
          if (mx_r == '0 || root_r == '0) st_r <= C_DONE;
          else st_r <= C_ANG2;
        end
        C_ANG2: if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) st_r <= C_DONE;
        C_DONE: st_r <= C_IDLE;
        default: st_r <= C_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      C_IDLE: begin
        mx_r    <= ax[15] ? 16'(-ax) : 16'(ax);
        my_r    <= ay[15] ? 16'(-ay) : 16'(ay);
        mz_r    <= az[15] ? 16'(-az) : 16'(az);
        zneg_r  <= az[15];
        undef_r <= (ax == '0) && (ay == '0) && (az == '0);
      end
      C_MUL: begin
        sqy_r <= my_r * my_r;
        sqz_r <= mz_r * mz_r;
      end
      C_SUM: begin
        rin_r  <= {1'b0, SQ_W'(sqy_r) + SQ_W'(sqz_r), 16'd0};
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      C_ROOT: begin
        rin_r <= {rin_r[RIN_W-3:0], 2'b00};
        cnt_r <= cnt_r + 1'b1;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      C_LD1: begin
        cnt_r <= '0;
        cx_r  <= CV_W'(mz_r);
        cy_r  <= CV_W'(my_r);
        cz_r  <= '0;
        if (my_r == '0) a1_r <= '0;
        else if (mz_r == '0) a1_r <= 15'(DEG90_Q8);
      end
      C_ANG1, C_ANG2: begin
        cx_r  <= cx_nxt;
        cy_r  <= cy_nxt;
        cz_r  <= cz_nxt;
        cnt_r <= cnt_r + 1'b1;
      end
      C_FIN1: a1_r <= rnd_q8(cz_r);
      C_LD2: begin
        cnt_r <= '0;
        cx_r  <= CV_W'(root_r);
        cy_r  <= CV_W'({mx_r, 8'd0});
        cz_r  <= '0;
        if (mx_r == '0) a2_r <= '0;
        else if (root_r == '0) a2_r <= 15'(DEG90_Q8);
      end
      C_DONE: begin
      end
      default: begin
      end
    endcase
    // the second pass rounds as it leaves its last step
    if (st_r == C_ANG2 && cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
      a2_r <= rnd_q8(cz_nxt);
    end
  end

  assign done      = (st_r == C_DONE);
  assign res.tx    = zneg_r ? 16'(a1_r) : 16'(DEG180_Q8) - 16'(a1_r);
  assign res.ty    = undef_r ? 15'd0 : a2_r;
  assign res.undef = undef_r;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives accelerometer samples into the tilt angle filter, predicts each
// angle pair, flag and moving average, and compares every result in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import tilt_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;

  // angle table, degrees with 16 fraction bits
  localparam longint ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // tilt predictor with its own window state
  class tilt_scoreboard;
    tilt_out_t   pending[$];
    logic [15:0] hist_x[WINDOW];
    logic [14:0] hist_y[WINDOW];
    int unsigned acc_x, acc_y, slot;
    int          mismatches;

    function new();
      foreach (hist_x[i]) begin
        hist_x[i] = '0;
        hist_y[i] = '0;
      end
      acc_x = 0;
      acc_y = 0;
      slot = 0;
      mismatches = 0;
    endfunction

    function longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -1 - ((-1 - v) >>> s);
    endfunction

    function longint int_root(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // vectoring rotation, angle of (x, y) in q8 degrees
    function int unsigned vec_angle(longint x, longint y);
      longint z, xs, ys;
      z = 0;
      if (y == 0) return 0;
      if (x == 0) return DEG90_Q8;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        xs = floor_shift(x, i);
        ys = floor_shift(y, i);
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_Q16[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_Q16[i];
        end
      end
      if (z < 0) z = 0;
      if (z > DEG90_Q16) z = DEG90_Q16;
      return int'((z + 128) >>> 8);
    endfunction

    function void note_request(tilt_in_t s);
      longint mx, my, mz, r;
      int unsigned a1, tx, ty;
      logic undef;
      tilt_out_t e;
      mx = s.acc_first < 0 ? -longint'(s.acc_first) : longint'(s.acc_first);
      mz = s.acc_second < 0 ? -longint'(s.acc_second) : longint'(s.acc_second);
      my = s.acc_third < 0 ? -longint'(s.acc_third) : longint'(s.acc_third);
      r = int_root((my * my + mz * mz) << 16);
      a1 = vec_angle(mz, my);
      tx = s.acc_second < 0 ? a1 : DEG180_Q8 - a1;
      ty = vec_angle(r, mx * 256);
      undef = (s.acc_first == 0) && (s.acc_second == 0) && (s.acc_third == 0);
      if (undef) ty = 0;
      acc_x = acc_x - hist_x[slot] + tx;
      acc_y = acc_y - hist_y[slot] + ty;
      hist_x[slot] = tx[15:0];
      hist_y[slot] = ty[14:0];
      slot = (slot + 1) % WINDOW;
      e.tilt_x = tx[15:0];
      e.tilt_y = ty[14:0];
      e.avg_tilt_x = 16'((acc_x + WINDOW / 2) / WINDOW);
      e.avg_tilt_y = 15'((acc_y + WINDOW / 2) / WINDOW);
      e.undefined_y = undef;
      pending.push_back(e);
    endfunction

    function void check_result(tilt_out_t got);
      tilt_out_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.tilt_x !== e.tilt_x || got.tilt_y !== e.tilt_y ||
          got.avg_tilt_x !== e.avg_tilt_x || got.avg_tilt_y !== e.avg_tilt_y ||
          got.undefined_y !== e.undefined_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
                   e.tilt_x, e.tilt_y, e.avg_tilt_x, e.avg_tilt_y, e.undefined_y,
                   got.tilt_x, got.tilt_y, got.avg_tilt_x, got.avg_tilt_y,
                   got.undefined_y);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  tilt_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  tilt_out_t out_data;

  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  longint         cycle_count = 0;
  tilt_scoreboard sb = new();

  accel_tilt_angle_filter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // accepted requests and results, sampled at the edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // timeout
  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // valid stays up after acceptance until the next idle cycle or new request
  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] z,
                             input logic signed [15:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{acc_first: x, acc_second: z, acc_third: y};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      3: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_sample(rand_axis(), rand_axis(), rand_axis());
    send_idle_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: all zero, axis extremes, y zero with both z signs
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd100, 16'sd0, 16'sd0);
    send_sample(-16'sd1, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd500, 16'sd0);
    send_sample(16'sd0, -16'sd500, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd300);
    send_sample(16'sd0, 16'sd0, -16'sd300);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(16'sd1, 16'sd1, 16'sd1);
    send_sample(-16'sd1, -16'sd1, -16'sd1);
    send_sample(16'sd0, -16'sd1, 16'sd1);
    send_sample(16'sd16384, 16'sd0, 16'sd16384);
    send_sample(16'sd0, 16'sh8000, 16'sd0);
    send_sample(16'sh8000, 16'sd0, 16'sd0);

    random_phase(500, 0, 0);
    random_phase(300, 81, 0);
    random_phase(300, 0, 81);
    random_phase(300, 32, 32);
    random_phase(300, 0, 0);
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
